[rtl/core/fbpa_pkg.sv]
// Shared types, field widths and codes of the fixed block pool allocator.
package fbpa_pkg;

  // Parameter defaults.
  localparam int DEF_MAX_BLOCKS = 1024;
  localparam int DEF_ADDR_WIDTH = 32;

  // Field and register widths.
  localparam int FIELD_ADDR_W = 32;
  localparam int SIZE_W       = 17;
  localparam int COUNT_W      = 11;
  localparam int REQ_W        = 17;
  localparam int STATUS_W     = 2;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int S_TDATA_W    = 56;
  localparam int M_TDATA_W    = 32;
  localparam int QUEUE_DEPTH  = 2;

  // Register reset values and the smallest usable block.
  localparam logic [FIELD_ADDR_W-1:0] RST_BASE       = 32'd0;
  localparam logic [SIZE_W-1:0]       RST_SIZE       = 17'd64;
  localparam logic [COUNT_W-1:0]      RST_COUNT      = 11'd1024;
  localparam logic [SIZE_W-1:0]       MIN_BLOCK_SIZE = 17'd8;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BASE  = 2'd0,
    REG_SIZE  = 2'd1,
    REG_COUNT = 2'd2
  } cfg_reg_t;

  // Request class decided by the front end.
  typedef enum logic [1:0] {
    OP_ALLOC     = 2'd0,
    OP_TOO_LARGE = 2'd1,
    OP_FREE      = 2'd2
  } op_kind_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_TOO_LARGE = 2'd2,
    STAT_RANGE     = 2'd3
  } status_t;

  // Back end sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR     = 4'd0,
    S_IDLE      = 4'd1,
    S_ALLOC_MUL = 4'd2,
    S_ALLOC_ADD = 4'd3,
    S_FREE_CAP  = 4'd4,
    S_FREE_CHK  = 4'd5,
    S_FREE_DIV  = 4'd6,
    S_FREE_WR   = 4'd7,
    S_RESULT    = 4'd8
  } back_state_t;

  // One result item.
  typedef struct packed {
    logic [FIELD_ADDR_W-1:0] block_address;
    status_t                 status;
  } result_t;

endpackage

[rtl/core/fixed_block_pool_allocator_unit.sv]
// An allocate passes the multiply, add and result states (straight to result when it fails); a free
// passes capacity, check, divide, list write and result (straight to result when out of range).
// The back end holds one request at a time and takes no new one until its result is loaded;
// the radix-2 divider forms one quotient bit per cycle.
// A two-entry queue lets the front end take requests while the back end works.
// Reset (synchronous, active high) and every block_count write start a pass over all MAX_BLOCKS
// list entries that rebuilds the free list; no request is accepted during it.
module fixed_block_pool_allocator_unit #(
  parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS,
  parameter int ADDR_WIDTH = fbpa_pkg::DEF_ADDR_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  // Request stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [fbpa_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // request_bytes, free_address
  input  logic                             s_axis_tuser,  // mode
  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [fbpa_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // block_address
  output logic [fbpa_pkg::STATUS_W-1:0]    m_axis_tuser,  // status
  // Configuration writes.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fbpa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fbpa_pkg::*;

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int KIND_W = $bits(op_kind_t);
  localparam int Q_W    = ADDR_WIDTH + KIND_W;

  logic [FIELD_ADDR_W-1:0] base_address;
  logic [SIZE_W-1:0]       block_size;
  logic [COUNT_W-1:0]      block_count;
  logic [SIZE_W-1:0]       eff_size;
  logic [CNT_W-1:0]        eff_count;
  logic                    cfg_write;
  logic                    rebuild;
  logic                    clearing;
  logic                    push_valid;
  logic                    push_ready;
  op_kind_t                push_kind;
  logic [ADDR_WIDTH-1:0]   push_offset;
  logic                    pop_valid;
  logic                    pop_ready;
  logic [Q_W-1:0]          pop_data;
  result_t                 out_res;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign rebuild   = cfg_write && (cfg_index == REG_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= RST_BASE;
      block_size   <= RST_SIZE;
      block_count  <= RST_COUNT;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_BASE:  base_address <= cfg_data[FIELD_ADDR_W-1:0];
        REG_SIZE:  block_size   <= cfg_data[SIZE_W-1:0];
        REG_COUNT: block_count  <= cfg_data[COUNT_W-1:0];
        default:   base_address <= base_address;
      endcase
    end
  end

  // Effective block size and block count.
  always_comb begin
    eff_size = (block_size < MIN_BLOCK_SIZE) ? MIN_BLOCK_SIZE : block_size;
    if (block_count == '0) begin
      eff_count = CNT_W'(1);
    end else if (32'(block_count) > MAX_BLOCKS) begin
      eff_count = CNT_W'(MAX_BLOCKS);
    end else begin
      eff_count = CNT_W'(block_count);
    end
  end

  fbpa_front #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_front (
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .mode          (s_axis_tuser),
    .request_bytes (s_axis_tdata[REQ_W-1:0]),
    .free_address  (s_axis_tdata[REQ_W +: FIELD_ADDR_W]),
    .base_address  (base_address),
    .eff_size      (eff_size),
    .hold          (clearing),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_kind     (push_kind),
    .push_offset   (push_offset)
  );

  fbpa_queue #(
    .DATA_W (Q_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_offset, push_kind}),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  fbpa_back #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_WIDTH (ADDR_WIDTH),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .rebuild      (rebuild),
    .base_address (base_address),
    .eff_size     (eff_size),
    .eff_count    (eff_count),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_kind     (op_kind_t'(pop_data[KIND_W-1:0])),
    .pop_offset   (pop_data[Q_W-1:KIND_W]),
    .clearing     (clearing),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_res      (out_res)
  );

  assign m_axis_tdata = out_res.block_address;
  assign m_axis_tuser = out_res.status;

  // The list rebuild is running once reset is released.
  a_clear_after_reset: assert property (@(posedge clk) (!rst && $past(rst)) |-> clearing)
    else $error("free list rebuild did not start after reset");

  // A block count write restarts the list rebuild.
  a_clear_after_count: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == REG_COUNT) |=> clearing)
    else $error("block count write did not start a list rebuild");

  // No request enters while the list is being rebuilt.
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready)
    else $error("request accepted during list rebuild");

endmodule

[rtl/core/fbpa_front.sv]
// Front end: accepts requests, checks allocate size and forms the free offset.
module fbpa_front #(
  parameter int ADDR_WIDTH = fbpa_pkg::DEF_ADDR_WIDTH
) (
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              mode,
  input  logic [fbpa_pkg::REQ_W-1:0]        request_bytes,
  input  logic [fbpa_pkg::FIELD_ADDR_W-1:0] free_address,
  input  logic [fbpa_pkg::FIELD_ADDR_W-1:0] base_address,
  input  logic [fbpa_pkg::SIZE_W-1:0]       eff_size,
  input  logic                              hold,
  output logic                              push_valid,
  input  logic                              push_ready,
  output fbpa_pkg::op_kind_t                push_kind,
  output logic [ADDR_WIDTH-1:0]             push_offset
);
  import fbpa_pkg::*;

  // No request is taken while the back end rebuilds the free list.
  assign in_ready   = push_ready && !hold;
  assign push_valid = in_valid && !hold;

  // An oversized allocate is settled here; the list state decides the rest.
  always_comb begin
    if (mode) begin
      push_kind = OP_FREE;
    end else if (request_bytes > eff_size) begin
      push_kind = OP_TOO_LARGE;
    end else begin
      push_kind = OP_ALLOC;
    end
  end

  // Byte offset from the pool base, wrapping at the address width.
  assign push_offset = ADDR_WIDTH'(free_address) - ADDR_WIDTH'(base_address);

endmodule

[rtl/core/fbpa_queue.sv]
// Short FIFO that decouples the front end from the back end.
module fbpa_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = fbpa_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  logic [DATA_W-1:0] wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output logic [DATA_W-1:0] rd_data
);
  import fbpa_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = (fill != CNT_W'(DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

[rtl/core/fbpa_div.sv]
// Radix-2 restoring divider that turns a byte offset into a block index.
module fbpa_div #(
  parameter int QUOT_W = 10,
  parameter int REM_W  = 27
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [REM_W-1:0]            dividend,
  input  logic [fbpa_pkg::SIZE_W-1:0] divisor,
  output logic                        done,
  output logic [QUOT_W-1:0]           quotient
);
  import fbpa_pkg::*;

  localparam int STEP_W = $clog2(QUOT_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  dsh;
  logic              take;

  // One quotient bit per cycle, most significant first.
  assign take = (rem >= dsh);

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(QUOT_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder, shifted divisor and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsh      <= REM_W'(divisor) << (QUOT_W - 1);
      quotient <= '0;
    end else if (busy) begin
      if (take) begin
        rem <= rem - dsh;
      end
      dsh      <= dsh >> 1;
      quotient <= QUOT_W'({quotient, take});
    end
  end

endmodule

[rtl/core/fbpa_back.sv]
// Back end: free list memory, list sequencer, address math and result register.
module fbpa_back #(
  parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS,
  parameter int ADDR_WIDTH = fbpa_pkg::DEF_ADDR_WIDTH,
  parameter int IDX_W      = $clog2(MAX_BLOCKS),
  parameter int CNT_W      = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              rebuild,
  input  logic [fbpa_pkg::FIELD_ADDR_W-1:0] base_address,
  input  logic [fbpa_pkg::SIZE_W-1:0]       eff_size,
  input  logic [CNT_W-1:0]                  eff_count,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  fbpa_pkg::op_kind_t                pop_kind,
  input  logic [ADDR_WIDTH-1:0]             pop_offset,
  output logic                              clearing,
  output logic                              out_valid,
  input  logic                              out_ready,
  output fbpa_pkg::result_t                 out_res
);
  import fbpa_pkg::*;

  localparam int CAP_W = CNT_W + SIZE_W;
  localparam int REM_W = IDX_W + SIZE_W;
  localparam int CMP_W = (ADDR_WIDTH > CAP_W) ? ADDR_WIDTH : CAP_W;
  localparam int SUM_W = ((CAP_W > FIELD_ADDR_W) ? CAP_W : FIELD_ADDR_W) + 1;
  localparam logic [FIELD_ADDR_W-1:0] OUT_MASK = (ADDR_WIDTH >= FIELD_ADDR_W) ?
      {FIELD_ADDR_W{1'b1}} : FIELD_ADDR_W'((64'd1 << ADDR_WIDTH) - 64'd1);

  back_state_t       state;
  back_state_t       state_next;
  logic [IDX_W-1:0]  clear_idx;
  logic [IDX_W:0]    clear_nxt;
  logic [IDX_W-1:0]  free_head;
  logic              head_valid;
  logic [IDX_W:0]    link_mem [MAX_BLOCKS];
  logic [IDX_W:0]    link_rd;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [IDX_W:0]    mem_wdata;
  logic [ADDR_WIDTH-1:0] offset_r;
  logic [CAP_W-1:0]  prod;
  logic [CNT_W-1:0]  mul_a;
  logic [SUM_W-1:0]  sum;
  logic              out_of_range;
  logic              out_free;
  logic              out_load;
  logic              div_start;
  logic              div_done;
  logic [IDX_W-1:0]  div_quot;
  result_t           res;

  // Shared datapath terms.
  assign clear_nxt    = {1'b0, clear_idx} + (IDX_W + 1)'(1);
  assign mul_a        = (state == S_FREE_CAP) ? eff_count : CNT_W'(free_head);
  assign sum          = SUM_W'(base_address) + SUM_W'(prod);
  assign out_of_range = (CMP_W'(offset_r) >= CMP_W'(prod));
  assign out_free     = !out_valid || out_ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clear_idx == IDX_W'(MAX_BLOCKS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop_valid) begin
          case (pop_kind)
            OP_ALLOC:     state_next = head_valid ? S_ALLOC_MUL : S_RESULT;
            OP_TOO_LARGE: state_next = S_RESULT;
            OP_FREE:      state_next = S_FREE_CAP;
            default:      state_next = S_IDLE;
          endcase
        end
      end
      S_ALLOC_MUL: state_next = S_ALLOC_ADD;
      S_ALLOC_ADD: state_next = S_RESULT;
      S_FREE_CAP:  state_next = S_FREE_CHK;
      S_FREE_CHK:  state_next = out_of_range ? S_RESULT : S_FREE_DIV;
      S_FREE_DIV: begin
        if (div_done) begin
          state_next = S_FREE_WR;
        end
      end
      S_FREE_WR: state_next = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (rebuild) begin
      state_next = S_CLEAR;
    end
  end

  // Control outputs of the sequencer.
  always_comb begin
    pop_ready = (state == S_IDLE);
    clearing  = (state == S_CLEAR);
    div_start = (state == S_FREE_CHK) && !out_of_range;
    out_load  = (state == S_RESULT) && out_free;
    mem_we    = 1'b0;
    mem_waddr = clear_idx;
    mem_wdata = {(32'(clear_nxt) < 32'(eff_count)), clear_nxt[IDX_W-1:0]};
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_FREE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = div_quot;
        mem_wdata = {head_valid, free_head};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer state, list head and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clear_idx  <= '0;
      free_head  <= '0;
      head_valid <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (rebuild) begin
        clear_idx  <= '0;
        free_head  <= '0;
        head_valid <= 1'b1;
      end else begin
        if (state == S_CLEAR) begin
          clear_idx <= clear_idx + IDX_W'(1);
        end
        // Pop: the head moves to its successor.
        if (state == S_ALLOC_MUL) begin
          free_head  <= link_rd[IDX_W-1:0];
          head_valid <= link_rd[IDX_W];
        end
        // Push: the freed block becomes the head.
        if (state == S_FREE_WR) begin
          free_head  <= div_quot;
          head_valid <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Link memory: one write port, one registered read at the list head.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    link_rd <= link_mem[free_head];
  end

  // Working registers and the result being built.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        offset_r <= pop_offset;
        res      <= '{block_address: '0,
                      status: (pop_kind == OP_TOO_LARGE) ? STAT_TOO_LARGE : STAT_EMPTY};
      end
      S_ALLOC_MUL, S_FREE_CAP: begin
        prod <= CAP_W'(mul_a) * CAP_W'(eff_size);
      end
      S_ALLOC_ADD: begin
        res <= '{block_address: sum[FIELD_ADDR_W-1:0] & OUT_MASK, status: STAT_OK};
      end
      S_FREE_CHK: begin
        if (out_of_range) begin
          res <= '{block_address: '0, status: STAT_RANGE};
        end
      end
      S_FREE_WR: begin
        res <= '{block_address: '0, status: STAT_OK};
      end
      default: begin
        res <= res;
      end
    endcase
    if (out_load) begin
      out_res <= res;
    end
  end

  // Offset to block index; the range check bounds the quotient to IDX_W bits.
  fbpa_div #(
    .QUOT_W (IDX_W),
    .REM_W  (REM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (REM_W'(offset_r)),
    .divisor  (eff_size),
    .done     (div_done),
    .quotient (div_quot)
  );

endmodule
